@@ rtl/core/tnon_pkg.sv @@
// shared types and protocol codes for the telnet option negotiator
package tnon_pkg;

    localparam int MASK_W       = 40;
    localparam int OPT_IDX_W    = $clog2(MASK_W);
    localparam int OPTION_COUNT = 40;

    localparam logic [MASK_W-1:0] MASK_RESET = 40'd10754228264;

    localparam logic [7:0] CODE_IAC  = 8'd255;
    localparam logic [7:0] CODE_DONT = 8'd254;
    localparam logic [7:0] CODE_DO   = 8'd253;
    localparam logic [7:0] CODE_WONT = 8'd252;
    localparam logic [7:0] CODE_WILL = 8'd251;
    localparam logic [7:0] CODE_SB   = 8'd250;
    localparam logic [7:0] CODE_SE   = 8'd240;

    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_IAC,
        PH_DO,
        PH_DONT,
        PH_SKIP,
        PH_SB,
        PH_SB_IAC
    } phase_t;

    typedef enum logic {
        KIND_DATA  = 1'b0,
        KIND_REPLY = 1'b1
    } kind_t;

    typedef logic [1:0] beat_t;
    localparam beat_t BEAT_FIRST = 2'd0;
    localparam beat_t BEAT_VERB  = 2'd1;
    localparam beat_t BEAT_LAST  = 2'd2;

    // one pending result burst: a data byte, or a reply IAC verb option
    typedef struct packed {
        kind_t      kind;
        logic [7:0] verb;
        logic [7:0] value;
    } rec_t;

endpackage

@@ rtl/core/tnon_if.sv @@
// valid/ready channel interfaces for received bytes and result beats
interface tnon_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tnon_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_kind, output out_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_kind, input out_byte, input out_last,
                    output ready);
endinterface

@@ rtl/core/telnet_option_negotiator.sv @@
// Telnet option negotiator: takes received bytes, passes data to the host and answers
// DO/DONT with a three-beat IAC WILL/WONT option reply. A byte is taken whenever the
// result register is empty or its final beat leaves in the same cycle, so data bytes
// run at one per cycle while out_ch.ready stays high; a DO or DONT option byte holds
// the result register for three beats, so the byte after it is taken with the third
// beat. Command and subnegotiation bytes give no beat and leave the result register
// untouched, so they are taken one per cycle while it is free.
module telnet_option_negotiator
#(
    parameter int OPTION_COUNT = tnon_pkg::OPTION_COUNT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tnon_pkg::MASK_W-1:0]  cfg_wdata,
    tnon_in_if.sink                      in_ch,
    tnon_out_if.source                   out_ch
);
    import tnon_pkg::*;

    logic accept;
    logic rec_valid;
    rec_t rec;
    logic free;

    assign in_ch.ready = free;
    assign accept      = in_ch.valid && in_ch.ready;

    tnon_parser
    #(
        .OPTION_COUNT (OPTION_COUNT)
    )
    u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .rx_byte   (in_ch.rx_byte),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    tnon_emitter u_emitter
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept && rec_valid),
        .rec    (rec),
        .free   (free),
        .out_ch (out_ch)
    );

    // a burst taken before its last beat keeps the output valid
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && !out_ch.out_last |=> out_ch.valid)
        else $error("reply burst cut short");

    // data beats are always single
    a_data_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.out_kind |-> out_ch.out_last)
        else $error("data beat without last");

    // input stalls only behind a pending result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_ch.valid)
        else $error("input stalled with empty result register");

    // a reply burst that follows an idle output opens with IAC
    a_reply_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.out_kind && !$past(out_ch.valid) |-> out_ch.out_byte == CODE_IAC)
        else $error("reply burst does not start with IAC");

endmodule

@@ rtl/core/tnon_parser.sv @@
// command parser: phase state machine, accept mask and reply decision
module tnon_parser
#(
    parameter int OPTION_COUNT = tnon_pkg::OPTION_COUNT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tnon_pkg::MASK_W-1:0]  cfg_wdata,
    input  logic                         accept,
    input  logic [7:0]                   rx_byte,
    output logic                         rec_valid,
    output tnon_pkg::rec_t               rec
);
    import tnon_pkg::*;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [MASK_W-1:0] mask_reg;
    logic              opt_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            mask_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NORMAL;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

    // options past the mask width or the option count, or with a clear mask bit, are refused
    assign opt_ok = (rx_byte < 8'(OPTION_COUNT)) && (rx_byte < 8'(MASK_W))
                    && mask_reg[rx_byte[OPT_IDX_W-1:0]];

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_NORMAL:
            begin
                if (rx_byte == CODE_IAC)
                    phase_next = PH_IAC;
            end
            PH_IAC:
            begin
                if (rx_byte == CODE_DO)
                    phase_next = PH_DO;
                else if (rx_byte == CODE_DONT)
                    phase_next = PH_DONT;
                else if (rx_byte inside {CODE_WILL, CODE_WONT})
                    phase_next = PH_SKIP;
                else if (rx_byte == CODE_SB)
                    phase_next = PH_SB;
                else
                    phase_next = PH_NORMAL;
            end
            PH_SB:
            begin
                if (rx_byte == CODE_IAC)
                    phase_next = PH_SB_IAC;
            end
            PH_SB_IAC:
            begin
                phase_next = (rx_byte == CODE_SE) ? PH_NORMAL : PH_SB;
            end
            default:
            begin
                phase_next = PH_NORMAL;
            end
        endcase
    end

    always_comb
    begin
        rec_valid  = 1'b0;
        rec.kind   = KIND_DATA;
        rec.verb   = CODE_WONT;
        rec.value  = rx_byte;
        case (phase_reg)
            PH_NORMAL:
            begin
                rec_valid = (rx_byte != CODE_IAC);
            end
            PH_DO:
            begin
                rec_valid = 1'b1;
                rec.kind  = KIND_REPLY;
                rec.verb  = opt_ok ? CODE_WILL : CODE_WONT;
            end
            PH_DONT:
            begin
                rec_valid = 1'b1;
                rec.kind  = KIND_REPLY;
            end
            default:
            begin
                rec_valid = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/tnon_emitter.sv @@
// result register: holds one burst and sends it out beat by beat
module tnon_emitter
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  tnon_pkg::rec_t rec,
    output logic           free,
    tnon_out_if.source     out_ch
);
    import tnon_pkg::*;

    rec_t  rec_reg;
    logic  full_reg;
    beat_t beat_reg;
    logic  take;

    assign take = out_ch.valid && out_ch.ready;
    assign free = !full_reg || (take && out_ch.out_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            beat_reg <= BEAT_FIRST;
        end
        else if (load)
        begin
            full_reg <= 1'b1;
            beat_reg <= BEAT_FIRST;
        end
        else if (take && out_ch.out_last)
        begin
            full_reg <= 1'b0;
        end
        else if (take)
        begin
            beat_reg <= beat_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec;
        end
    end

    assign out_ch.valid    = full_reg;
    assign out_ch.out_kind = rec_reg.kind;
    assign out_ch.out_last = (rec_reg.kind == KIND_DATA) || (beat_reg == BEAT_LAST);

    always_comb
    begin
        if (rec_reg.kind == KIND_DATA)
        begin
            out_ch.out_byte = rec_reg.value;
        end
        else
        begin
            case (beat_reg)
                BEAT_FIRST: out_ch.out_byte = CODE_IAC;
                BEAT_VERB:  out_ch.out_byte = rec_reg.verb;
                default:    out_ch.out_byte = rec_reg.value;
            endcase
        end
    end

endmodule
